/* rtl/scpa_pkg.sv */
// Shared types, constants and tables for the size-class pool allocator.
// Depends on nothing. Used by size_class_pool_allocator and by the bench.
`default_nettype none

package scpa_pkg;

  // Build-time sizing of the allocator.
  localparam int unsigned NumClasses    = 8;
  localparam int unsigned SlotsPerClass = 256;
  localparam int unsigned WordBytes     = 8;

  // The class field names at most eight classes, and a slot fits in eight bits.
  localparam int unsigned ClsMax    = (NumClasses < 8) ? NumClasses : 8;
  localparam int unsigned ClsW      = (ClsMax > 1) ? $clog2(ClsMax) : 1;
  localparam int unsigned UseSlots  = (SlotsPerClass < 256) ? SlotsPerClass : 256;
  localparam int unsigned SlotW     = $clog2(UseSlots);
  localparam int unsigned CntW      = $clog2(UseSlots + 1);
  localparam int unsigned LinkW     = SlotW + 1;
  localparam int unsigned LinkDepth = ClsMax << SlotW;
  localparam int unsigned LinkAddrW = $clog2(LinkDepth);

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    StsOk        = 2'd0,
    StsOversize  = 2'd1,
    StsExhausted = 2'd2
  } status_e;

  // Request and response payloads.
  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] request_size;
    logic [7:0]  free_slot;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] class_index;
    logic [7:0] slot_index;
    logic       reused;
  } rsp_t;

  // Wraps an 8-bit slot number into the usable slot range of a class.
  typedef logic [SlotW-1:0] wrap_tab_t [256];

  function automatic wrap_tab_t build_wrap_tab();
    wrap_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = SlotW'(i % UseSlots);
    end
    return tab;
  endfunction

  localparam wrap_tab_t SlotWrap = build_wrap_tab();

endpackage

`default_nettype wire

/* rtl/size_class_pool_allocator.sv */
// Size-class pool allocator: class selection, per-class free lists and bump counters.
// Depends on scpa_pkg and on scpa_ram for the link store.
//
//   Channel  Direction  Signals                          Contents
//   in       input      in_valid_i / in_ready_o          req_t: opcode, size, slot
//   out      output     out_valid_o / out_ready_i        rsp_t: status, class, slot, reused
//   cfg      input      cfg_we_i / cfg_wdata_i           classes_in_use, no wait
//
// A transaction retires in the execute state, or in the wait state when it pops a free
// list, since the pop reads the next link from the link memory before the head updates.
// Back-to-back frees, bump allocations and errors sustain one per cycle while the output
// is taken; a pop holds off the input until it retires. Reset clears the heads, list flags
// and bump counters at once; the link memory needs no clearing pass. A full output register
// that is not taken holds the transaction in flight, and the input stalls until it retires.
`default_nettype none

module size_class_pool_allocator
  import scpa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire req_t       in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output rsp_t            out_data_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StWait = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       cfg_q;
  opcode_e          req_op_q;
  logic [ClsW-1:0]  req_cls_q, req_cls_d;
  logic             req_over_q, req_over_d;
  logic [SlotW-1:0] req_slot_q;
  logic [SlotW-1:0] head_q [ClsMax];
  logic [SlotW-1:0] head_d [ClsMax];
  logic [ClsMax-1:0] nonempty_q, nonempty_d;
  logic [CntW-1:0]  bump_q [ClsMax];
  logic [CntW-1:0]  bump_d [ClsMax];
  logic             out_valid_q, out_valid_d;
  rsp_t             out_data_q, out_data_d;

  logic             out_free, pop_go, commit, accept;
  logic [3:0]       active;
  logic [SlotW-1:0] cur_head;
  logic [CntW-1:0]  cur_bump;
  rsp_t             rsp;
  logic             ram_we;
  logic [LinkAddrW-1:0] ram_waddr, ram_raddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 4'd8;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Class selection: the smallest active class whose capacity holds the size.
  always_comb begin
    active     = (cfg_q > 4'(ClsMax)) ? 4'(ClsMax) : cfg_q;
    req_cls_d  = '0;
    req_over_d = 1'b1;
    for (int i = ClsMax - 1; i >= 0; i--) begin
      if ((i < int'(active)) &&
          ({1'b0, in_data_i.request_size} <= (17'(WordBytes) << i))) begin
        req_cls_d  = ClsW'(unsigned'(i));
        req_over_d = 1'b0;
      end
    end
  end

  // Handshake control.
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_go   = (state_q == StExec) && (req_op_q == OpAlloc) && !req_over_q &&
                    nonempty_q[req_cls_q];
  assign commit   = ((state_q == StExec) && !pop_go && out_free) ||
                    ((state_q == StWait) && out_free);
  assign in_ready_o = (state_q == StIdle) || commit;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StExec;
      end
      StExec: begin
        if (pop_go) begin
          state_d = StWait;
        end else if (commit) begin
          state_d = accept ? StExec : StIdle;
        end
      end
      StWait: begin
        if (commit) state_d = accept ? StExec : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Request register, loaded on each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_op_q   <= in_data_i.opcode;
      req_cls_q  <= req_cls_d;
      req_over_q <= req_over_d;
      req_slot_q <= SlotWrap[in_data_i.free_slot];
    end
  end

  assign cur_head = head_q[req_cls_q];
  assign cur_bump = bump_q[req_cls_q];

  // Result and read-modify-write of the per-class state.
  always_comb begin
    head_d      = head_q;
    nonempty_d  = nonempty_q;
    bump_d      = bump_q;
    ram_we      = 1'b0;
    ram_waddr   = LinkAddrW'({req_cls_q, req_slot_q});
    ram_wdata   = {nonempty_q[req_cls_q], cur_head};
    rsp.status      = StsOk;
    rsp.class_index = 3'(req_cls_q);
    rsp.slot_index  = '0;
    rsp.reused      = 1'b0;
    if (state_q == StWait) begin
      // Pop: the head leaves, and its stored link becomes the new head.
      rsp.slot_index = 8'(cur_head);
      rsp.reused     = 1'b1;
      if (commit) begin
        head_d[req_cls_q]     = ram_rdata[SlotW-1:0];
        nonempty_d[req_cls_q] = ram_rdata[SlotW];
      end
    end else if (req_over_q) begin
      rsp.status      = StsOversize;
      rsp.class_index = '0;
    end else if (req_op_q == OpFree) begin
      // Push: the old head is linked below the freed slot.
      if (commit) begin
        ram_we                = 1'b1;
        head_d[req_cls_q]     = req_slot_q;
        nonempty_d[req_cls_q] = 1'b1;
      end
    end else if (cur_bump < CntW'(UseSlots)) begin
      rsp.slot_index = 8'(cur_bump);
      if (commit) bump_d[req_cls_q] = cur_bump + CntW'(1);
    end else begin
      rsp.status = StsExhausted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '{default: '0};
      nonempty_q <= '0;
      bump_q     <= '{default: '0};
    end else begin
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      bump_q     <= bump_d;
    end
  end

  // Link store: next slot and its presence flag for every pushed slot.
  assign ram_raddr = LinkAddrW'({req_cls_q, cur_head});

  scpa_ram #(
    .Width (LinkW),
    .Depth (LinkDepth)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_go),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (commit) begin
      out_valid_d = 1'b1;
      out_data_d  = rsp;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A pop read is always followed by the wait for its link data.
  a_pop_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_go |=> (state_q == StWait))
    else $error("pop read not followed by link wait");

  // A retirement never lands on a result that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(out_data_q) || !$past(out_valid_q)))
    else $error("pending result overwritten");

  // A reused slot is only reported with an ok status.
  a_reuse_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reused) |-> (out_data_o.status == StsOk))
    else $error("reused flag on a failed request");

  // Oversize results name class zero and no slot.
  a_oversize_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StsOversize)) |->
      ((out_data_o.class_index == 3'd0) && (out_data_o.slot_index == 8'd0)))
    else $error("oversize result carries class or slot");

endmodule

`default_nettype wire

/* rtl/scpa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the free-list link store.
`default_nettype none

module scpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the size-class pool allocator: directed table, then random phases.
// Depends on scpa_pkg for the payload types and on size_class_pool_allocator as the block.
`timescale 1ns / 100ps

module tb_top;
  import scpa_pkg::*;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] size;
    logic [7:0]  slot;
  } held_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  // Shadow copy of the allocator state.
  int unsigned pool_cfg = 8;
  bit [7:0] pool_head [8];
  bit pool_filled [8];
  int unsigned pool_bump [8];
  bit [7:0] pool_next [8][256];
  bit pool_next_ok [8][256];

  rsp_t awaited_rsp [$];
  held_t held_slots [$];
  dir_row_t dir_rows [$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_reused = 0;
  int n_exhausted = 0;
  int n_oversize = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_tgl = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int phase_cfg [5] = '{15, 1, 0, 4, 8};
  int phase_len [5] = '{60, 320, 20, 30, 20};
  int phase_alloc [5] = '{60, 95, 50, 55, 50};

  size_class_pool_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Number of classes that the register value actually enables.
  function automatic int active_count();
    int n;
    n = pool_cfg & 'hF;
    if (n > NumClasses) n = NumClasses;
    if (n > 8) n = 8;
    return n;
  endfunction

  // Smallest active class that holds the size, or -1 when it is oversize.
  function automatic int class_for(int unsigned size);
    int n;
    n = active_count();
    for (int i = 0; i < n; i++) begin
      if (size <= (WordBytes << i)) return i;
    end
    return -1;
  endfunction

  // Computes the response to one request and advances the shadow state.
  function automatic rsp_t pool_response(req_t r);
    rsp_t o;
    int c;
    int s;
    bit [7:0] h;
    o = '0;
    o.status = StsOk;
    c = class_for(r.request_size);
    if (c < 0) begin
      o.status = StsOversize;
    end else begin
      o.class_index = 3'(c);
      if (r.opcode == OpAlloc) begin
        if (pool_filled[c]) begin
          h = pool_head[c];
          o.slot_index = h;
          o.reused = 1'b1;
          pool_head[c] = pool_next[c][h];
          pool_filled[c] = pool_next_ok[c][h];
        end else if (pool_bump[c] < UseSlots) begin
          o.slot_index = 8'(pool_bump[c]);
          pool_bump[c]++;
        end else begin
          o.status = StsExhausted;
        end
      end else begin
        s = int'(r.free_slot) % UseSlots;
        pool_next[c][s] = pool_head[c];
        pool_next_ok[c][s] = pool_filled[c];
        pool_head[c] = 8'(s);
        pool_filled[c] = 1'b1;
      end
    end
    return o;
  endfunction

  // Size inside a random class, with an occasional size drawn from the full range.
  function automatic logic [15:0] pick_size(int n);
    int c;
    int cap;
    int lo;
    if ($urandom_range(0, 99) < 10) return 16'($urandom_range(0, 65535));
    c = (n == 0) ? $urandom_range(0, 7) : $urandom_range(0, n - 1);
    cap = WordBytes << c;
    lo = (c == 0) ? 0 : (cap / 2) + 1;
    return 16'($urandom_range(lo, cap));
  endfunction

  // Random request: frees mostly return a slot that is really held, the rest is noise.
  function automatic req_t make_request(int alloc_pct);
    req_t r;
    int n;
    int k;
    n = active_count();
    r.free_slot = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < alloc_pct) begin
      r.opcode = OpAlloc;
      r.request_size = pick_size(n);
    end else begin
      r.opcode = OpFree;
      if (held_slots.size() > 0 && $urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, held_slots.size() - 1);
        r.request_size = held_slots[k].size;
        r.free_slot = held_slots[k].slot;
        held_slots.delete(k);
      end else begin
        r.request_size = pick_size(n);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb_top: mismatch: %s", msg);
    errors++;
  endtask

  task automatic add_row(opcode_e op, int sz, int fs, bit typed, status_e st, int ci,
                         int si, bit ru);
    dir_row_t row;
    row.req.opcode = op;
    row.req.request_size = 16'(sz);
    row.req.free_slot = 8'(fs);
    row.typed = typed;
    row.rsp.status = st;
    row.rsp.class_index = 3'(ci);
    row.rsp.slot_index = 8'(si);
    row.rsp.reused = ru;
    dir_rows.push_back(row);
  endtask

  // Offers one request, records its expected response at acceptance, then maybe idles.
  task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t want;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    want = pool_response(r);
    if (typed) want = typed_rsp;
    awaited_rsp.push_back(want);
    n_sent++;
    if (r.opcode == OpAlloc && want.status == StsOk) begin
      held_slots.push_back('{r.request_size, want.slot_index});
    end
    if (tx_idle_en && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 15);
    end
  endtask

  // Stops offering and waits until every outstanding response has come back.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_rsp.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the class count while the block is idle.
  task automatic write_classes(int v);
    wait_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 4'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_cfg = v;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= 80;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(rx_idle_en && $urandom_range(0, 99) < 15);
    end
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("response with nothing outstanding (status %0d slot %0d)",
                                  out_data_o.status, out_data_o.slot_index));
      end else begin
        want = awaited_rsp.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("response %0d status: got %0d, want %0d", n_checked,
                                    out_data_o.status, want.status));
        if (out_data_o.class_index !== want.class_index)
          report_mismatch($sformatf("response %0d class_index: got %0d, want %0d", n_checked,
                                    out_data_o.class_index, want.class_index));
        if (out_data_o.slot_index !== want.slot_index)
          report_mismatch($sformatf("response %0d slot_index: got %0d, want %0d", n_checked,
                                    out_data_o.slot_index, want.slot_index));
        if (out_data_o.reused !== want.reused)
          report_mismatch($sformatf("response %0d reused: got %0d, want %0d", n_checked,
                                    out_data_o.reused, want.reused));
        n_checked++;
        if (want.reused) n_reused++;
        if (want.status == StsExhausted) n_exhausted++;
        if (want.status == StsOversize) n_oversize++;
      end
    end
  end

  // Stimulus: reset, directed table, then random phases under several class counts.
  initial begin
    rsp_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh state with all eight classes: bump order, class edges, oversize.
    add_row(OpAlloc, 0, 0, 1, StsOk, 0, 0, 0);
    add_row(OpAlloc, 8, 0, 1, StsOk, 0, 1, 0);
    add_row(OpAlloc, 9, 0, 1, StsOk, 1, 0, 0);
    add_row(OpAlloc, 16, 0, 1, StsOk, 1, 1, 0);
    add_row(OpAlloc, 1024, 0, 1, StsOk, 7, 0, 0);
    add_row(OpAlloc, 1025, 0, 1, StsOversize, 0, 0, 0);
    add_row(OpAlloc, 65535, 255, 1, StsOversize, 0, 0, 0);
    add_row(OpFree, 65535, 255, 1, StsOversize, 0, 0, 0);
    // Free-list pushes and pops, double free, allocate with a nonzero slot field.
    add_row(OpFree, 1, 1, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 5, 0, 0, StsOk, 0, 0, 0);
    add_row(OpFree, 0, 255, 0, StsOk, 0, 0, 0);
    add_row(OpFree, 0, 255, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 0, 0, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 0, 0, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 2, 255, 0, StsOk, 0, 0, 0);
    add_row(OpFree, 1024, 0, 0, StsOk, 0, 0, 0);
    add_row(OpFree, 1024, 128, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 600, 0, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 513, 0, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 1000, 0, 0, StsOk, 0, 0, 0);
    add_row(OpFree, 100, 'hAA, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 128, 'h55, 0, StsOk, 0, 0, 0);
    add_row(OpFree, 300, 'h55, 0, StsOk, 0, 0, 0);
    add_row(OpAlloc, 257, 0, 0, StsOk, 0, 0, 0);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    // Random phases; the single-class phase runs class 0 into exhaustion.
    for (int p = 0; p < 5; p++) begin
      write_classes(phase_cfg[p]);
      for (int k = 0; k < phase_len[p]; k++) begin
        tx_idle_en = !(p == 1 && k < 150);
        rx_idle_en = tx_idle_en;
        if (p == 3 && k == 5) hold_tgl = ~hold_tgl;
        send_req(make_request(phase_alloc[p]), 1'b0, none);
      end
    end

    wait_results();
    repeat (8) @(posedge clk_i);
    $display("tb_top: %0d requests sent, %0d responses checked under class counts 8,15,1,0,4,8",
             n_sent, n_checked);
    $display("tb_top: %0d free-list reuses, %0d exhausted, %0d oversize responses",
             n_reused, n_exhausted, n_oversize);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/scpa_pkg.sv
rtl/scpa_ram.sv
rtl/size_class_pool_allocator.sv
bench/tb_top.sv
